### rtl/core/dcfr_pkg.sv
// shared types and constants of the delimited command frame receiver
package dcfr_pkg;

	// frame geometry
	localparam int PAYLOAD_BYTES = 14;
	localparam int LENGTH_OFFSET = 1;
	localparam int ERROR_OFFSET  = 3;
	localparam int STORE_DEPTH   = 16;
	localparam int STORE_AW      = $clog2(STORE_DEPTH);
	localparam int TIME_BYTES    = 7;
	localparam int TIME_W        = 8 * TIME_BYTES;

	// destination byte that marks a time set frame
	localparam logic [7:0] TIME_MARK = 8'h54;

	// byte masks for the big-endian length
	localparam logic [15:0] LEN_HI_MASK = 16'hff00;
	localparam logic [15:0] LEN_LO_MASK = 16'h00ff;

	// result kinds
	localparam logic [1:0] KIND_CMD   = 2'd0;
	localparam logic [1:0] KIND_TIME  = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd2;

	// configuration register indexes
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;
	localparam logic [CFG_IW-1:0] REG_START_ONE = 3'd0;
	localparam logic [CFG_IW-1:0] REG_START_TWO = 3'd1;
	localparam logic [CFG_IW-1:0] REG_END_ONE   = 3'd2;
	localparam logic [CFG_IW-1:0] REG_END_TWO   = 3'd3;
	localparam logic [CFG_IW-1:0] REG_BOARD_ID  = 3'd4;
	localparam logic [CFG_IW-1:0] REG_LEN_MIN   = 3'd5;
	localparam logic [CFG_IW-1:0] REG_LEN_MAX   = 3'd6;
	localparam logic [CFG_IW-1:0] REG_STOP_MASK = 3'd7;

	// queue sizes
	localparam int CMD_Q_DEPTH = 2;
	localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);
	localparam int CMD_Q_CW    = $clog2(CMD_Q_DEPTH + 1);
	localparam int RES_Q_DEPTH = 2;
	localparam int RES_Q_AW    = $clog2(RES_Q_DEPTH);
	localparam int RES_Q_CW    = $clog2(RES_Q_DEPTH + 1);

	typedef struct packed {
		logic [7:0]  start_one;
		logic [7:0]  start_two;
		logic [7:0]  end_one;
		logic [7:0]  end_two;
		logic [7:0]  board_id;
		logic [15:0] len_min;
		logic [15:0] len_max;
		logic [7:0]  stop_mask;
	} cfg_t;

	// snapshot of one completed frame, as the back end needs it
	typedef struct packed {
		logic [7:0]        dest;
		logic [15:0]       len;
		logic [7:0]        err;
		logic [TIME_W-1:0] tfields;
	} frame_rec_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic              accepted;
		logic [15:0]       length;
		logic              stop;
		logic              ok;
		logic [TIME_W-1:0] tfields;
	} result_t;

endpackage

### rtl/core/dcfr_front.sv
// front end: delimiter hunt, payload capture and frame snapshot
module dcfr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         rx_byte,
	input  dcfr_pkg::cfg_t     cfg,
	output logic               rec_valid,
	output dcfr_pkg::frame_rec_t rec
);
	import dcfr_pkg::*;

	typedef enum logic [4:0] {
		PH_START1 = 5'b00001,
		PH_START2 = 5'b00010,
		PH_DATA   = 5'b00100,
		PH_END1   = 5'b01000,
		PH_END2   = 5'b10000
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [STORE_AW-1:0] count_q, count_d;
	logic [7:0]          store_q [STORE_DEPTH];
	logic                store_we;

	// phase update per accepted item
	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		store_we  = 1'b0;
		rec_valid = 1'b0;
		if (accept) begin
			case (phase_q)
				PH_START1: begin
					if (rx_byte == cfg.start_one) phase_d = PH_START2;
				end
				PH_START2: begin
					if (rx_byte == cfg.start_two) begin
						phase_d = PH_DATA;
						count_d = '0;
					end else begin
						phase_d = PH_START1;
					end
				end
				PH_DATA: begin
					store_we = 1'b1;
					count_d  = count_q + 1'b1;
					if (count_q == STORE_AW'(PAYLOAD_BYTES - 1)) phase_d = PH_END1;
				end
				PH_END1: begin
					phase_d = (rx_byte == cfg.end_one) ? PH_END2 : PH_START1;
				end
				PH_END2: begin
					rec_valid = (rx_byte == cfg.end_two);
					phase_d   = PH_START1;
					count_d   = '0;
				end
				default: begin
					phase_d = PH_START1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START1;
			count_q <= '0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	// payload store, written at the running count
	always_ff @(posedge clk) begin
		if (store_we) store_q[count_q] <= rx_byte;
	end

	// snapshot of the fields used by the back end
	always_comb begin
		rec.dest = store_q[0];
		rec.len  = ({store_q[LENGTH_OFFSET], 8'h00} & LEN_HI_MASK)
			| ({8'h00, store_q[LENGTH_OFFSET + 1]} & LEN_LO_MASK);
		rec.err  = store_q[ERROR_OFFSET];
		for (int i = 1; i <= TIME_BYTES; i++) begin
			rec.tfields[(TIME_BYTES - i) * 8 +: 8] = store_q[STORE_AW'(i)];
		end
	end

endmodule

### rtl/core/dcfr_cmd_q.sv
// short queue of completed frames between front and back end
module dcfr_cmd_q (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  dcfr_pkg::frame_rec_t wr_data,
	output logic                 full,
	input  logic                 rd_en,
	output dcfr_pkg::frame_rec_t rd_data,
	output logic                 empty
);
	import dcfr_pkg::*;

	frame_rec_t          mem_q [CMD_Q_DEPTH];
	logic [CMD_Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMD_Q_CW-1:0] cnt_q;
	logic                do_wr, do_rd;

	assign full    = (cnt_q == CMD_Q_CW'(CMD_Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == CMD_Q_AW'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == CMD_Q_AW'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### rtl/core/dcfr_back.sv
// back end: frame classification, length check, flags and result queue
module dcfr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dcfr_pkg::cfg_t       cfg,
	input  logic                 rec_avail,
	input  dcfr_pkg::frame_rec_t rec,
	output logic                 rec_take,
	input  logic                 pop,
	output logic                 empty,
	output dcfr_pkg::result_t    res
);
	import dcfr_pkg::*;

	logic [15:0]         held_len_q;
	logic                stop_q;
	result_t             res_d;
	logic                in_range;

	result_t             mem_q [RES_Q_DEPTH];
	logic [RES_Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [RES_Q_CW-1:0] cnt_q;
	logic                res_full, do_rd;

	assign res_full = (cnt_q == RES_Q_CW'(RES_Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign rec_take = rec_avail && !res_full;
	assign do_rd    = pop && !empty;
	assign res      = mem_q[rd_ptr_q];

	assign in_range = (rec.len >= cfg.len_min) && (rec.len <= cfg.len_max);

	// result of the frame at the queue head; board id wins over the time mark
	// link ok drops for an out-of-range command; only the result carries it
	always_comb begin
		res_d.kind     = KIND_OTHER;
		res_d.accepted = 1'b0;
		res_d.length   = held_len_q;
		res_d.stop     = stop_q;
		res_d.ok       = 1'b1;
		res_d.tfields  = '0;
		if (rec.dest == cfg.board_id) begin
			res_d.kind     = KIND_CMD;
			res_d.accepted = in_range;
			res_d.ok       = in_range;
			res_d.stop     = |(rec.err & cfg.stop_mask);
			if (in_range) res_d.length = rec.len;
		end else if (rec.dest == TIME_MARK) begin
			res_d.kind    = KIND_TIME;
			res_d.tfields = rec.tfields;
		end
	end

	// held state, updated as each frame is carried out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_len_q <= '0;
			stop_q     <= 1'b0;
		end else if (rec_take) begin
			held_len_q <= res_d.length;
			stop_q     <= res_d.stop;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (rec_take) mem_q[wr_ptr_q] <= res_d;
	end

	// result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (rec_take) begin
				wr_ptr_q <= (wr_ptr_q == RES_Q_AW'(RES_Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == RES_Q_AW'(RES_Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (rec_take && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !rec_take) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### rtl/core/delimited_command_frame_receiver_top.sv
// top level of the delimited command frame receiver
// Takes one received byte per cycle through a push/full port and hands one result per
// completed frame out through an empty/pop port. The front end follows the start, payload
// and end delimiters one byte a cycle; a frame that closes is snapshotted into a two-entry
// queue, and the back end classifies it, checks the length against the limits and updates
// the held length and stop flag, writing the result into a two-entry result queue; a full
// result queue holds the frame back. A byte is taken every cycle unless the frame queue is
// full. Configuration writes are taken at once and should be made only while no frame is
// in flight.
module delimited_command_frame_receiver_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [dcfr_pkg::CFG_IW-1:0] cfg_index,
	input  logic [dcfr_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  rx_byte,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  frame_kind,
	output logic                        length_accepted,
	output logic [15:0]                 material_length,
	output logic                        soft_stop,
	output logic                        link_ok,
	output logic [dcfr_pkg::TIME_W-1:0] time_fields
);
	import dcfr_pkg::*;

	cfg_t       cfg_q;
	logic       accept;
	logic       rec_valid;
	frame_rec_t rec_in, rec_out;
	logic       cmd_full, cmd_empty, rec_take;
	result_t    res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_one <= 8'd2;
			cfg_q.start_two <= 8'd13;
			cfg_q.end_one   <= 8'd11;
			cfg_q.end_two   <= 8'd10;
			cfg_q.board_id  <= 8'd0;
			cfg_q.len_min   <= 16'd0;
			cfg_q.len_max   <= 16'hffff;
			cfg_q.stop_mask <= 8'd1;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_START_ONE: cfg_q.start_one <= cfg_data[7:0];
				REG_START_TWO: cfg_q.start_two <= cfg_data[7:0];
				REG_END_ONE:   cfg_q.end_one   <= cfg_data[7:0];
				REG_END_TWO:   cfg_q.end_two   <= cfg_data[7:0];
				REG_BOARD_ID:  cfg_q.board_id  <= cfg_data[7:0];
				REG_LEN_MIN:   cfg_q.len_min   <= cfg_data;
				REG_LEN_MAX:   cfg_q.len_max   <= cfg_data;
				REG_STOP_MASK: cfg_q.stop_mask <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	dcfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.cfg       (cfg_q),
		.rec_valid (rec_valid),
		.rec       (rec_in)
	);

	dcfr_cmd_q u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_valid),
		.wr_data (rec_in),
		.full    (cmd_full),
		.rd_en   (rec_take),
		.rd_data (rec_out),
		.empty   (cmd_empty)
	);

	dcfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rec_avail (!cmd_empty),
		.rec       (rec_out),
		.rec_take  (rec_take),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	// result fields
	assign frame_kind      = res.kind;
	assign length_accepted = res.accepted;
	assign material_length = res.length;
	assign soft_stop       = res.stop;
	assign link_ok         = res.ok;
	assign time_fields     = res.tfields;

	// a completed frame never meets a full frame queue
	a_no_frame_loss: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> !cmd_full)
		else $error("frame completed while frame queue full");

	// only board commands can accept a length
	a_accept_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && length_accepted) |-> (frame_kind == KIND_CMD))
		else $error("length accepted on a non-command frame");

	// an accepted length leaves the link ok
	a_accept_link: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && length_accepted) |-> link_ok)
		else $error("accepted length without link ok");

	// time bytes appear on time set frames only
	a_time_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_kind != KIND_TIME) |-> (time_fields == '0))
		else $error("time fields on a non-time frame");

endmodule
